>>> hw/rtl/iir_filter_df2t_defines.svh
// assertion macros for the filter rtl
`ifndef IIR_FILTER_DF2T_DEFINES_SVH
`define IIR_FILTER_DF2T_DEFINES_SVH

// same-cycle implication
`define IIR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IIR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/iirdf2t_pkg.sv
package iirdf2t_pkg;

    localparam int ORDER           = 3;
    localparam int SAMPLE_WIDTH    = 24;
    localparam int COEF_WIDTH      = 32;
    localparam int COEF_FRAC       = 28;
    localparam int ACC_WIDTH       = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int DIGIT_WIDTH     = 4;
    localparam int NUM_DIGITS      = COEF_WIDTH / DIGIT_WIDTH;
    localparam int NUM_LANES       = ORDER + 1;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CNT_WIDTH       = $clog2(NUM_DIGITS);
    localparam int LANE_IDX_WIDTH  = $clog2(NUM_LANES);
    localparam int DLY_IDX_WIDTH   = $clog2(ORDER);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;
    typedef logic signed [ACC_WIDTH-1:0]    acc_t;

    localparam acc_t    ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam acc_t    ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam sample_t SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam sample_t SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    localparam coef_t COEF_B0_RESET = coef_t'(32'h1000_0000);

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B3 = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_A1 = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_A2 = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_A3 = 3'd6;

    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } lane_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_B,
        ST_ADD_B,
        ST_ROUND,
        ST_MUL_A,
        ST_ADD_A,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/iirdf2t_mul.sv
module iirdf2t_mul (
    input  logic                    clk,
    input  iirdf2t_pkg::lane_ctl_t  ctl,
    input  iirdf2t_pkg::sample_t    mcand,
    input  iirdf2t_pkg::coef_t      coef,
    output iirdf2t_pkg::acc_t       product
);
    import iirdf2t_pkg::*;

    localparam int HI_WIDTH = SAMPLE_WIDTH + 1;
    localparam int PP_WIDTH = SAMPLE_WIDTH + DIGIT_WIDTH + 1;

    sample_t                      mcand_reg;
    logic [COEF_WIDTH-1:0]        coef_reg;
    logic signed [HI_WIDTH-1:0]   hi_reg;
    logic signed [HI_WIDTH-1:0]   hi_next;
    logic [COEF_WIDTH-1:0]        lo_reg;
    logic [COEF_WIDTH-1:0]        lo_next;
    logic signed [DIGIT_WIDTH:0]  digit;
    logic signed [PP_WIDTH-1:0]   pp;
    logic signed [PP_WIDTH-1:0]   sum;

    // top digit of the coefficient carries the sign
    always_comb
    begin
        if (ctl.last)
        begin
            digit = {coef_reg[DIGIT_WIDTH-1], coef_reg[DIGIT_WIDTH-1:0]};
        end
        else
        begin
            digit = {1'b0, coef_reg[DIGIT_WIDTH-1:0]};
        end
        pp      = mcand_reg * digit;
        sum     = $signed({{(PP_WIDTH-HI_WIDTH){hi_reg[HI_WIDTH-1]}}, hi_reg}) + pp;
        hi_next = sum[PP_WIDTH-1:DIGIT_WIDTH];
        lo_next = {sum[DIGIT_WIDTH-1:0], lo_reg[COEF_WIDTH-1:DIGIT_WIDTH]};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mcand_reg <= mcand;
            coef_reg  <= coef;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end
        else if (ctl.step)
        begin
            coef_reg <= {{DIGIT_WIDTH{1'b0}}, coef_reg[COEF_WIDTH-1:DIGIT_WIDTH]};
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
        end
    end

    assign product = {hi_reg[SAMPLE_WIDTH-1:0], lo_reg};

endmodule

>>> hw/rtl/iir_filter_df2t.sv
// one sample at a time: in_stall stays high from the input transfer until the sequencer
//   is back in idle; each sample takes two passes of the 4-bit digit-serial multipliers
//   over the 32-bit coefficients, 8 add and round steps, the done state, held while the
//   output is stalled, and the idle state that takes the transfer
// reset: rst_n asynchronous active low; clears the delay line, coefficients
//   (b0 = 1.0, others 0), the sequencer and out_valid
module iir_filter_df2t (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [iirdf2t_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  iirdf2t_pkg::coef_t                         cfg_data,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  iirdf2t_pkg::sample_t                       sample_in,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output iirdf2t_pkg::sample_t                       sample_out,
    output logic                                       clipped
);
    import iirdf2t_pkg::*;

    `include "iir_filter_df2t_defines.svh"

    localparam int YW = ACC_WIDTH - COEF_FRAC + 1;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CNT_WIDTH-1:0]    cnt_reg;
    logic [CNT_WIDTH-1:0]    cnt_next;
    lane_ctl_t               lane_ctl;
    logic                    out_load;

    coef_t                   coef_b_reg [NUM_LANES];
    coef_t                   coef_a_reg [ORDER];
    acc_t                    z_reg      [ORDER];
    acc_t                    zn         [NUM_LANES];
    acc_t                    prod       [NUM_LANES];
    acc_t                    acc_reg;
    sample_t                 y_reg;
    logic                    clip_reg;
    logic                    out_valid_reg;
    sample_t                 sample_out_reg;
    logic                    clipped_reg;

    logic [LANE_IDX_WIDTH-1:0] lane_idx;
    logic [LANE_IDX_WIDTH-1:0] prod_idx;
    logic                      add_sub;
    logic signed [ACC_WIDTH:0] add_a;
    logic signed [ACC_WIDTH:0] add_b;
    logic signed [ACC_WIDTH:0] add_sum;
    logic                      add_ovf;
    acc_t                      add_res;
    logic signed [YW-1:0]      y_wide;
    logic                      y_ovf;
    sample_t                   y_val;
    sample_t                   lane_mcand;

    // multiplier lanes
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        coef_t lane_coef;
        if (i == 0)
        begin : g_b0
            assign lane_coef = (state_reg == ST_IDLE) ? coef_b_reg[i] : '0;
        end
        else
        begin : g_ba
            assign lane_coef = (state_reg == ST_IDLE) ? coef_b_reg[i] : coef_a_reg[i-1];
        end
        iirdf2t_mul u_mul (
            .clk     (clk),
            .ctl     (lane_ctl),
            .mcand   (lane_mcand),
            .coef    (lane_coef),
            .product (prod[i])
        );
    end

    assign lane_mcand = (state_reg == ST_IDLE) ? sample_in : y_val;

    // shared saturating adder
    always_comb
    begin
        for (int k = 0; k < ORDER; k++)
        begin
            zn[k] = z_reg[k];
        end
        zn[ORDER] = '0;
        lane_idx  = cnt_reg[LANE_IDX_WIDTH-1:0];
        add_sub   = (state_reg == ST_ADD_A);
        prod_idx  = add_sub ? lane_idx + 1'b1 : lane_idx;
        if (add_sub)
        begin
            add_a = {zn[lane_idx][ACC_WIDTH-1], zn[lane_idx]};
            add_b = {prod[prod_idx][ACC_WIDTH-1], prod[prod_idx]};
            add_sum = add_a - add_b;
        end
        else
        begin
            add_a = {prod[prod_idx][ACC_WIDTH-1], prod[prod_idx]};
            add_b = {zn[lane_idx][ACC_WIDTH-1], zn[lane_idx]};
            add_sum = add_a + add_b;
        end
        add_ovf = add_sum[ACC_WIDTH] != add_sum[ACC_WIDTH-1];
        if (add_ovf)
        begin
            add_res = add_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            add_res = add_sum[ACC_WIDTH-1:0];
        end
    end

    // round half up, then saturate to the sample range
    always_comb
    begin
        y_wide = $signed({acc_reg[ACC_WIDTH-1], acc_reg[ACC_WIDTH-1:COEF_FRAC]})
               + $signed({{(YW-1){1'b0}}, acc_reg[COEF_FRAC-1]});
        y_ovf  = !((&y_wide[YW-1:SAMPLE_WIDTH-1]) || !(|y_wide[YW-1:SAMPLE_WIDTH-1]));
        if (y_ovf)
        begin
            y_val = y_wide[YW-1] ? SMP_MIN : SMP_MAX;
        end
        else
        begin
            y_val = y_wide[SAMPLE_WIDTH-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lane_ctl   = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    lane_ctl.load = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_MUL_B;
                end
            end
            ST_MUL_B, ST_MUL_A:
            begin
                lane_ctl.step = 1'b1;
                lane_ctl.last = (cnt_reg == CNT_WIDTH'(NUM_DIGITS - 1));
                cnt_next      = cnt_reg + 1'b1;
                if (lane_ctl.last)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == ST_MUL_B) ? ST_ADD_B : ST_ADD_A;
                end
            end
            ST_ADD_B:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_WIDTH'(ORDER))
                begin
                    cnt_next   = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                lane_ctl.load = 1'b1;
                cnt_next      = '0;
                state_next    = ST_MUL_A;
            end
            ST_ADD_A:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_WIDTH'(ORDER - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_LANES; k++)
            begin
                coef_b_reg[k] <= '0;
            end
            coef_b_reg[0] <= COEF_B0_RESET;
            for (int k = 0; k < ORDER; k++)
            begin
                coef_a_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_B0:  coef_b_reg[0] <= cfg_data;
                REG_B1:  coef_b_reg[1] <= cfg_data;
                REG_B2:  coef_b_reg[2] <= cfg_data;
                REG_B3:  coef_b_reg[3] <= cfg_data;
                REG_A1:  coef_a_reg[0] <= cfg_data;
                REG_A2:  coef_a_reg[1] <= cfg_data;
                REG_A3:  coef_a_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // delay line and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ORDER; k++)
            begin
                z_reg[k] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_ADD_B && cnt_reg != '0)
            begin
                z_reg[DLY_IDX_WIDTH'(cnt_reg - 1'b1)] <= add_res;
            end
            else if (state_reg == ST_ADD_A)
            begin
                z_reg[cnt_reg[DLY_IDX_WIDTH-1:0]] <= add_res;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            clip_reg <= 1'b0;
        end
        else if (state_reg == ST_ADD_B || state_reg == ST_ADD_A)
        begin
            clip_reg <= clip_reg | add_ovf;
        end
        else if (state_reg == ST_ROUND)
        begin
            clip_reg <= clip_reg | y_ovf;
        end
        if (state_reg == ST_ADD_B && cnt_reg == '0)
        begin
            acc_reg <= add_res;
        end
        if (state_reg == ST_ROUND)
        begin
            y_reg <= y_val;
        end
        if (out_load)
        begin
            sample_out_reg <= y_reg;
            clipped_reg    <= clip_reg;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

    `IIR_ASSERT_NXT(a_transfer_starts_mul, in_valid && !in_stall,
        state_reg == ST_MUL_B && cnt_reg == '0, "input transfer did not start multiply")
    `IIR_ASSERT_NXT(a_round_to_mul_a, state_reg == ST_ROUND,
        state_reg == ST_MUL_A && cnt_reg == '0, "feedback multiply did not follow rounding")
    `IIR_ASSERT_IMP(a_out_from_done, $rose(out_valid_reg),
        $past(state_reg) == ST_DONE, "output valid rose outside done state")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import iirdf2t_pkg::*;

    localparam int NUM_COEFS = 7;
    localparam int LATENCY = 25;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES = 15;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 3'd7;
    localparam coef_t COEF_ONE = COEF_B0_RESET;
    localparam coef_t COEF_HALF = coef_t'(32'h0800_0000);
    localparam coef_t COEF_MAX = coef_t'(32'h7fff_ffff);
    localparam coef_t COEF_MIN = coef_t'(32'h8000_0000);

    typedef enum int {
        MODE_GENTLE,
        MODE_FULL,
        MODE_EXTREME,
        MODE_MODERATE
    } coef_mode_t;

    typedef struct {
        sample_t smp;
        logic clip;
    } filt_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    coef_t cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    sample_t sample_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    sample_t sample_out;
    logic clipped;

    coef_t coef_shadow [NUM_COEFS];
    longint delay_line [3];
    filt_out_t pending_outputs [$];

    int in_idle_pct = 22;
    int out_stall_pct = 22;
    int failures = 0;
    int samples_sent = 0;
    int outputs_seen = 0;
    int clip_count = 0;
    int settings_used = 1;
    int quiet_cycles = 0;

    iir_filter_df2t uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample_in(sample_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample_out(sample_out),
        .clipped(clipped)
    );

    always #2 clk = ~clk;

    function automatic longint sat_acc(input longint v, inout logic flag);
        if (v > longint'(ACC_MAX))
        begin
            flag = 1'b1;
            return longint'(ACC_MAX);
        end
        if (v < longint'(ACC_MIN))
        begin
            flag = 1'b1;
            return longint'(ACC_MIN);
        end
        return v;
    endfunction

    function automatic filt_out_t filter_step(input sample_t s);
        filt_out_t res;
        logic flag;
        longint x;
        longint acc;
        longint y;
        longint nxt;
        longint part;
        flag = 1'b0;
        x = longint'(s);
        acc = sat_acc(longint'(coef_shadow[REG_B0]) * x + delay_line[0], flag);
        y = (acc >>> COEF_FRAC) + longint'(acc[COEF_FRAC-1]);
        if (y > longint'(SMP_MAX))
        begin
            y = longint'(SMP_MAX);
            flag = 1'b1;
        end
        if (y < longint'(SMP_MIN))
        begin
            y = longint'(SMP_MIN);
            flag = 1'b1;
        end
        for (int i = 0; i < ORDER; i++)
        begin
            nxt = (i + 1 < ORDER) ? delay_line[i+1] : 64'sd0;
            part = sat_acc(longint'(coef_shadow[REG_B0 + i + 1]) * x + nxt, flag);
            delay_line[i] = sat_acc(part - longint'(coef_shadow[REG_A1 + i]) * y, flag);
        end
        res.smp = sample_t'(y);
        res.clip = flag;
        return res;
    endfunction

    // output side: random stall and result check
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge clk)
    begin
        filt_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            outputs_seen++;
            if (clipped)
                clip_count++;
            if (pending_outputs.size() == 0)
            begin
                $error("output transfer with no sample pending: sample_out %0d", sample_out);
                failures++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (sample_out !== want.smp)
                begin
                    $error("sample_out expected %0d actual %0d", want.smp, sample_out);
                    failures++;
                end
                if (clipped !== want.clip)
                begin
                    $error("clipped expected %0d actual %0d", want.clip, clipped);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_sample(input sample_t s);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_in <= s;
        do
            @(posedge clk);
        while (in_stall);
        pending_outputs.insert(pending_outputs.size(), filter_step(s));
        samples_sent++;
    endtask

    // wait until every output has arrived, then let the pipeline go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input coef_t val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx < NUM_COEFS)
            coef_shadow[idx] = val;
    endtask

    task automatic test_passthrough();
        send_sample(sample_t'(0));
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(sample_t'(1));
        send_sample(sample_t'(-1));
        settle();
    endtask

    task automatic test_output_saturation();
        write_reg(REG_B0, COEF_MAX);
        settings_used++;
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(sample_t'(2));
        settle();
    endtask

    task automatic test_accumulator_saturation();
        write_reg(REG_B1, COEF_MAX);
        write_reg(REG_B2, COEF_MIN);
        write_reg(REG_A1, COEF_MIN);
        write_reg(REG_A2, COEF_MAX);
        settings_used++;
        send_sample(SMP_MAX);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(SMP_MIN);
        send_sample(SMP_MAX);
        settle();
    endtask

    // half-way cases round up for both signs
    task automatic test_rounding();
        write_reg(REG_B0, COEF_HALF);
        write_reg(REG_B1, '0);
        write_reg(REG_B2, '0);
        write_reg(REG_A1, '0);
        write_reg(REG_A2, '0);
        settings_used++;
        send_sample(sample_t'(1));
        send_sample(sample_t'(-1));
        send_sample(sample_t'(3));
        send_sample(sample_t'(-3));
        settle();
    endtask

    task automatic test_spare_index();
        write_reg(REG_B0, COEF_ONE);
        write_reg(REG_SPARE, COEF_MIN);
        write_reg(REG_SPARE, COEF_MAX);
        send_sample(sample_t'(12345));
        send_sample(sample_t'(-54321));
        settle();
    endtask

    function automatic coef_t pick_coef(input coef_mode_t mode);
        case (mode)
            MODE_GENTLE:   return coef_t'($signed($urandom_range(32'h1000_0000)) - 32'sh0800_0000);
            MODE_MODERATE: return coef_t'($signed($urandom_range(32'h4000_0000)) - 32'sh2000_0000);
            MODE_EXTREME:
            begin
                case ($urandom_range(4))
                    0: return COEF_MAX;
                    1: return COEF_MIN;
                    2: return COEF_ONE;
                    3: return -COEF_ONE;
                    default: return '0;
                endcase
            end
            default:       return coef_t'($urandom);
        endcase
    endfunction

    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return ($urandom_range(1) != 0) ? SMP_MAX : SMP_MIN;
        if (r < 30)
            return sample_t'($signed($urandom_range(512)) - 256);
        return sample_t'($urandom);
    endfunction

    task automatic test_random_settings();
        coef_mode_t mode;
        int count;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            mode = coef_mode_t'(p % 4);
            for (int r = 0; r < NUM_COEFS; r++)
                write_reg(r[CFG_INDEX_WIDTH-1:0], pick_coef(mode));
            if ($urandom_range(3) == 0)
                write_reg(REG_SPARE, coef_t'($urandom));
            settings_used++;
            // one phase runs with no idling on either side
            in_idle_pct = (p == 5) ? 0 : 22;
            out_stall_pct = in_idle_pct;
            count = $urandom_range(125, 85);
            for (int i = 0; i < count; i++)
                send_sample(pick_sample());
            settle();
        end
        in_idle_pct = 22;
        out_stall_pct = 22;
    endtask

    initial
    begin
        for (int r = 0; r < NUM_COEFS; r++)
            coef_shadow[r] = '0;
        coef_shadow[REG_B0] = COEF_ONE;
        for (int i = 0; i < 3; i++)
            delay_line[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_output_saturation();
        test_accumulator_saturation();
        test_rounding();
        test_spare_index();
        test_random_settings();

        settle();
        $display("tb: %0d samples through %0d coefficient settings, %0d outputs checked",
                 samples_sent, settings_used, outputs_seen);
        $display("tb: %0d outputs flagged as clipped", clip_count);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/iirdf2t_pkg.sv
hw/rtl/iirdf2t_mul.sv
hw/rtl/iir_filter_df2t.sv
tb/testbench.sv
